// ===== rtl/core/rbsh_pkg.sv =====
package rbsh_pkg;

  // Default geometry of the fixed-point coordinates
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Epsilon register
  localparam int          EPS_BITS  = 16;
  localparam logic [15:0] EPS_RESET = 16'd1;

  // Per-item flags that ride alongside the divider lanes
  typedef struct packed {
    logic valid;
    logic par_x;
    logic par_y;
    logic miss_x;
    logic miss_y;
  } rbsh_side_t;

endpackage

// ===== rtl/core/rbsh_prep.sv =====
module rbsh_prep
  import rbsh_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [EPS_BITS-1:0]          eps,
  input  logic signed [COORD_BITS-1:0] origin_x,
  input  logic signed [COORD_BITS-1:0] origin_y,
  input  logic signed [COORD_BITS-1:0] dir_x,
  input  logic signed [COORD_BITS-1:0] dir_y,
  input  logic signed [COORD_BITS-1:0] box_left,
  input  logic signed [COORD_BITS-1:0] box_top,
  input  logic [COORD_BITS-2:0]        box_width,
  input  logic [COORD_BITS-2:0]        box_height,
  output logic [COORD_BITS:0]          num_lo_x,
  output logic [COORD_BITS:0]          num_hi_x,
  output logic [COORD_BITS:0]          num_lo_y,
  output logic [COORD_BITS:0]          num_hi_y,
  output logic [COORD_BITS-1:0]        den_x,
  output logic [COORD_BITS-1:0]        den_y,
  output logic                         neg_lo_x,
  output logic                         neg_hi_x,
  output logic                         neg_lo_y,
  output logic                         neg_hi_y,
  output rbsh_side_t                   side
);

  localparam int C = COORD_BITS;

  // Stage 1: capture the beat
  logic                v1;
  logic signed [C-1:0] ox1, oy1, dx1, dy1, bx1, by1;
  logic [C-2:0]        bw1, bh1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    ox1 <= origin_x;
    oy1 <= origin_y;
    dx1 <= dir_x;
    dy1 <= dir_y;
    bx1 <= box_left;
    by1 <= box_top;
    bw1 <= box_width;
    bh1 <= box_height;
  end

  // Stage 2: slab edges relative to origin, direction magnitude, parallel test
  logic                  v2;
  logic signed [C+1:0]   nlx2, nhx2, nly2, nhy2;
  logic signed [C+1:0]   nlx_next, nhx_next, nly_next, nhy_next;
  logic [C-1:0]          dmx2, dmy2, dmx_next, dmy_next;
  logic                  dnx2, dny2, parx2, pary2, parx_next, pary_next;

  always_comb begin
    nlx_next  = {{2{bx1[C-1]}}, bx1} - {{2{ox1[C-1]}}, ox1};
    nhx_next  = {{2{bx1[C-1]}}, bx1} + {3'b000, bw1} - {{2{ox1[C-1]}}, ox1};
    nly_next  = {{2{by1[C-1]}}, by1} - {{2{oy1[C-1]}}, oy1};
    nhy_next  = {{2{by1[C-1]}}, by1} + {3'b000, bh1} - {{2{oy1[C-1]}}, oy1};
    dmx_next  = dx1[C-1] ? C'(-dx1) : C'(dx1);
    dmy_next  = dy1[C-1] ? C'(-dy1) : C'(dy1);
    parx_next = (dx1 == '0) || (dmx_next < C'(eps));
    pary_next = (dy1 == '0) || (dmy_next < C'(eps));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    nlx2  <= nlx_next;
    nhx2  <= nhx_next;
    nly2  <= nly_next;
    nhy2  <= nhy_next;
    dmx2  <= dmx_next;
    dmy2  <= dmy_next;
    dnx2  <= dx1[C-1];
    dny2  <= dy1[C-1];
    parx2 <= parx_next;
    pary2 <= pary_next;
  end

  // Stage 3: numerator magnitudes, quotient signs, in-slab test
  logic inx, iny;

  assign inx = (nlx2 <= 0) && (nhx2 >= 0);
  assign iny = (nly2 <= 0) && (nhy2 >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    num_lo_x    <= nlx2[C+1] ? (C+1)'(-nlx2) : (C+1)'(nlx2);
    num_hi_x    <= nhx2[C+1] ? (C+1)'(-nhx2) : (C+1)'(nhx2);
    num_lo_y    <= nly2[C+1] ? (C+1)'(-nly2) : (C+1)'(nly2);
    num_hi_y    <= nhy2[C+1] ? (C+1)'(-nhy2) : (C+1)'(nhy2);
    den_x       <= dmx2;
    den_y       <= dmy2;
    neg_lo_x    <= nlx2[C+1] ^ dnx2;
    neg_hi_x    <= nhx2[C+1] ^ dnx2;
    neg_lo_y    <= nly2[C+1] ^ dny2;
    neg_hi_y    <= nhy2[C+1] ^ dny2;
    side.par_x  <= parx2;
    side.par_y  <= pary2;
    side.miss_x <= parx2 && !inx;
    side.miss_y <= pary2 && !iny;
  end

endmodule

// ===== rtl/core/rbsh_div.sv =====
module rbsh_div
  import rbsh_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic [COORD_BITS:0]          num,
  input  logic [COORD_BITS-1:0]        den,
  input  logic                         neg,
  output logic signed [COORD_BITS-1:0] quot
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int RW = C + 1;
  localparam int OW = 2 * C - F + 2;
  localparam logic [C-1:0] LIM_POS = {1'b0, {(C-1){1'b1}}};
  localparam logic [C-1:0] LIM_NEG = {1'b1, {(C-1){1'b0}}};

  logic [RW-1:0] rem [0:C];
  logic [C-1:0]  quo [0:C];
  logic [C-1:0]  low [0:C];
  logic [C-1:0]  dv  [0:C];
  logic          ng  [0:C];
  logic          ov  [0:C];

  // Setup: catch quotients of C bits or more, seed the remainder
  always_ff @(posedge clk) begin
    ov[0]  <= (OW'(num) >= OW'({den, {(C-F){1'b0}}}));
    rem[0] <= RW'(num >> (C - F));
    low[0] <= C'({num, {F{1'b0}}});
    quo[0] <= '0;
    dv[0]  <= den;
    ng[0]  <= neg;
  end

  // One quotient bit per stage, restoring
  genvar k;
  generate
    for (k = 1; k <= C; k++) begin : g_step
      logic [RW-1:0] trial;
      logic          take;

      assign trial = {rem[k-1][RW-2:0], low[k-1][C-1]};
      assign take  = (trial >= {1'b0, dv[k-1]});

      always_ff @(posedge clk) begin
        rem[k] <= take ? (trial - {1'b0, dv[k-1]}) : trial;
        quo[k] <= {quo[k-1][C-2:0], take};
        low[k] <= {low[k-1][C-2:0], 1'b0};
        dv[k]  <= dv[k-1];
        ng[k]  <= ng[k-1];
        ov[k]  <= ov[k-1];
      end
    end
  endgenerate

  // Saturate and apply sign
  logic [C-1:0] lim, mag;

  assign lim = ng[C] ? LIM_NEG : LIM_POS;
  assign mag = (ov[C] || (quo[C] > lim)) ? lim : quo[C];

  always_ff @(posedge clk) begin
    quot <= ng[C] ? -$signed(mag) : $signed(mag);
  end

endmodule

// ===== rtl/core/rbsh_resolve.sv =====
module rbsh_resolve
  import rbsh_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [COORD_BITS-1:0] t_lo_x,
  input  logic signed [COORD_BITS-1:0] t_hi_x,
  input  logic signed [COORD_BITS-1:0] t_lo_y,
  input  logic signed [COORD_BITS-1:0] t_hi_y,
  input  rbsh_side_t                   side,
  output logic                         done,
  output logic                         hit,
  output logic [COORD_BITS-2:0]        distance
);

  localparam int C = COORD_BITS;
  localparam logic signed [C:0] POS_INF = {2'b01, {(C-1){1'b0}}};
  localparam logic signed [C:0] NEG_INF = ~POS_INF;

  // Stage 1: order entry and exit per axis
  rbsh_side_t          s1;
  logic signed [C-1:0] enx, exx, eny, exy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= side.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1.par_x  <= side.par_x;
    s1.par_y  <= side.par_y;
    s1.miss_x <= side.miss_x;
    s1.miss_y <= side.miss_y;
    enx <= (t_lo_x > t_hi_x) ? t_hi_x : t_lo_x;
    exx <= (t_lo_x > t_hi_x) ? t_lo_x : t_hi_x;
    eny <= (t_lo_y > t_hi_y) ? t_hi_y : t_lo_y;
    exy <= (t_lo_y > t_hi_y) ? t_lo_y : t_hi_y;
  end

  // Stage 2: intersect the axis intervals, parallel axes leave them open
  logic              v2, ok2;
  logic signed [C:0] tmin2, tmax2;
  logic signed [C:0] inx, iny, outx, outy;

  assign inx  = s1.par_x ? NEG_INF : (C+1)'(enx);
  assign iny  = s1.par_y ? NEG_INF : (C+1)'(eny);
  assign outx = s1.par_x ? POS_INF : (C+1)'(exx);
  assign outy = s1.par_y ? POS_INF : (C+1)'(exy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    ok2   <= !s1.miss_x && !s1.miss_y;
    tmin2 <= (inx > iny) ? inx : iny;
    tmax2 <= (outx < outy) ? outx : outy;
  end

  // Stage 3: pick the nearest non-negative time
  logic              hit_next;
  logic signed [C:0] t_next;

  always_comb begin
    hit_next = 1'b0;
    t_next   = '0;
    if (ok2 && !(tmax2 < 0) && !(tmin2 > tmax2)) begin
      if (tmin2 >= 0) begin
        hit_next = 1'b1;
        t_next   = tmin2;
      end else if (tmax2 != POS_INF) begin
        hit_next = 1'b1;
        t_next   = tmax2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    hit      <= hit_next;
    distance <= hit_next ? t_next[C-2:0] : '0;
  end

endmodule

// ===== rtl/core/ray_box_slab_hit_unit.sv =====
// Throughput: one beat per cycle; busy is held low, start is taken every cycle.
// The four quotients run in parallel lanes, one quotient bit per stage.
// Reset (rst, synchronous): clears all valid bits and sets axis_epsilon to 1.
// The receiver cannot stall: each result shows for one cycle with done high.
module ray_box_slab_hit_unit
  import rbsh_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we,
  input  logic [EPS_BITS-1:0]          cfg_wdata,
  input  logic signed [COORD_BITS-1:0] origin_x,
  input  logic signed [COORD_BITS-1:0] origin_y,
  input  logic signed [COORD_BITS-1:0] dir_x,
  input  logic signed [COORD_BITS-1:0] dir_y,
  input  logic signed [COORD_BITS-1:0] box_left,
  input  logic signed [COORD_BITS-1:0] box_top,
  input  logic [COORD_BITS-2:0]        box_width,
  input  logic [COORD_BITS-2:0]        box_height,
  output logic                         done,
  output logic                         hit,
  output logic [COORD_BITS-2:0]        distance
);

  localparam int C       = COORD_BITS;
  localparam int DIV_LAT = C + 2;
  localparam int LAT     = C + 8;

  assign busy = 1'b0;

  // Epsilon register
  logic [EPS_BITS-1:0] axis_epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_epsilon <= EPS_RESET;
    end else if (cfg_we) begin
      axis_epsilon <= cfg_wdata;
    end
  end

  // Front end
  logic [C:0]   nlx, nhx, nly, nhy;
  logic [C-1:0] dnx, dny;
  logic         sglx, sghx, sgly, sghy;
  rbsh_side_t   side_p;

  rbsh_prep #(.COORD_BITS(C)) u_prep (
    .clk(clk), .rst(rst), .start(start), .eps(axis_epsilon),
    .origin_x(origin_x), .origin_y(origin_y), .dir_x(dir_x), .dir_y(dir_y),
    .box_left(box_left), .box_top(box_top),
    .box_width(box_width), .box_height(box_height),
    .num_lo_x(nlx), .num_hi_x(nhx), .num_lo_y(nly), .num_hi_y(nhy),
    .den_x(dnx), .den_y(dny),
    .neg_lo_x(sglx), .neg_hi_x(sghx), .neg_lo_y(sgly), .neg_hi_y(sghy),
    .side(side_p)
  );

  // Divider lanes
  logic signed [C-1:0] tlx, thx, tly, thy;

  rbsh_div #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div_lx (
    .clk(clk), .num(nlx), .den(dnx), .neg(sglx), .quot(tlx)
  );
  rbsh_div #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div_hx (
    .clk(clk), .num(nhx), .den(dnx), .neg(sghx), .quot(thx)
  );
  rbsh_div #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div_ly (
    .clk(clk), .num(nly), .den(dny), .neg(sgly), .quot(tly)
  );
  rbsh_div #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div_hy (
    .clk(clk), .num(nhy), .den(dny), .neg(sghy), .quot(thy)
  );

  // Carry the flags alongside the dividers
  rbsh_side_t side_q [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      side_q[0] <= side_p;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Back end
  rbsh_resolve #(.COORD_BITS(C)) u_resolve (
    .clk(clk), .rst(rst),
    .t_lo_x(tlx), .t_hi_x(thx), .t_lo_y(tly), .t_hi_y(thy),
    .side(side_q[DIV_LAT-1]),
    .done(done), .hit(hit), .distance(distance)
  );

  // Checks
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result strobe without a matching start");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (distance == '0))
    else $error("miss carries a nonzero distance");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("start refused");

endmodule

// ===== bench/ray_box_slab_hit_unit_tb.sv =====
`timescale 1ns / 1ps

module ray_box_slab_hit_unit_tb;
  import rbsh_pkg::*;

  localparam int CB = 32;
  localparam int FB = 16;
  localparam int LATENCY = CB + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_RAYS = 1250;
  localparam longint HALF = 64'sd1 << (CB - 1);
  localparam longint T_POS_INF = HALF;
  localparam longint T_NEG_INF = -HALF - 1;

  typedef struct {
    logic signed [CB-1:0] ox, oy, dx, dy, bl, bt;
    logic [CB-2:0] bw, bh;
  } ray_box_t;

  typedef struct packed {
    logic hit;
    logic [CB-2:0] tval;
  } slab_hit_t;

  // directed row: stimulus plus optional known answer
  typedef struct {
    ray_box_t rb;
    bit known;
    slab_hit_t ans;
  } directed_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic cfg_we;
  logic [EPS_BITS-1:0] cfg_wdata;
  logic signed [CB-1:0] origin_x, origin_y, dir_x, dir_y, box_left, box_top;
  logic [CB-2:0] box_width, box_height;
  logic done;
  logic hit;
  logic [CB-2:0] distance;

  logic [EPS_BITS-1:0] eps_model;
  slab_hit_t hit_queue[$];
  int errors;
  int rays_sent;
  int hits_seen;
  int misses_seen;
  int idle_cycles;
  bit timed_out;

  ray_box_slab_hit_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .origin_x(origin_x), .origin_y(origin_y), .dir_x(dir_x), .dir_y(dir_y),
    .box_left(box_left), .box_top(box_top),
    .box_width(box_width), .box_height(box_height),
    .done(done), .hit(hit), .distance(distance)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // quotient num * 2^FB / den, truncated toward zero and saturated
  function automatic longint slab_quotient(longint num, longint den);
    logic [63:0] un, ud, q, r, mag, lim;
    bit neg;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    lim = neg ? HALF : HALF - 1;
    q = un / ud;
    r = un % ud;
    if (q > (lim >> FB)) begin
      mag = lim;
    end else begin
      mag = q;
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        mag = mag << 1;
        if (r >= ud) begin
          r = r - ud;
          mag[0] = 1'b1;
        end
      end
      if (mag > lim) mag = lim;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // narrow the running interval by one slab; zero means a certain miss
  function automatic bit clip_slab(longint o, longint d, longint lo, longint hi,
                                   inout longint tmin, inout longint tmax);
    longint t1, t2, tt;
    longint ad;
    ad = (d < 0) ? -d : d;
    if (d == 0 || ad < longint'(eps_model)) return !(o < lo || o > hi);
    t1 = slab_quotient(lo - o, d);
    t2 = slab_quotient(hi - o, d);
    if (t1 > t2) begin
      tt = t1;
      t1 = t2;
      t2 = tt;
    end
    if (t1 > tmin) tmin = t1;
    if (t2 < tmax) tmax = t2;
    return 1'b1;
  endfunction

  function automatic slab_hit_t nearest_hit(ray_box_t rb);
    slab_hit_t res;
    longint tmin, tmax, ox, oy, bx, by;
    tmin = T_NEG_INF;
    tmax = T_POS_INF;
    res.hit = 1'b0;
    res.tval = '0;
    ox = rb.ox;
    oy = rb.oy;
    bx = rb.bl;
    by = rb.bt;
    if (clip_slab(ox, rb.dx, bx, bx + longint'(rb.bw), tmin, tmax) &&
        clip_slab(oy, rb.dy, by, by + longint'(rb.bh), tmin, tmax)) begin
      if (tmax < 0 || tmin > tmax) begin
        res.hit = 1'b0;
      end else if (tmin >= 0) begin
        res.hit = 1'b1;
        res.tval = tmin[CB-2:0];
      end else if (tmax != T_POS_INF) begin
        res.hit = 1'b1;
        res.tval = tmax[CB-2:0];
      end
    end
    return res;
  endfunction

  function automatic ray_box_t mk(longint ox, longint oy, longint dx, longint dy,
                                  longint bl, longint bt, longint bw, longint bh);
    ray_box_t rb;
    rb.ox = CB'(ox); rb.oy = CB'(oy); rb.dx = CB'(dx); rb.dy = CB'(dy);
    rb.bl = CB'(bl); rb.bt = CB'(bt); rb.bw = (CB-1)'(bw); rb.bh = (CB-1)'(bh);
    return rb;
  endfunction

  // random coordinate: mostly near the box scale, sometimes any bits
  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return CB'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
      default: return CB'($signed($urandom_range(0, 32'h00080000)) - 32'sh00040000);
    endcase
  endfunction

  function automatic ray_box_t rand_ray();
    ray_box_t rb;
    rb.ox = rand_coord();
    rb.oy = rand_coord();
    rb.dx = rand_coord();
    rb.dy = rand_coord();
    rb.bl = rand_coord();
    rb.bt = rand_coord();
    rb.bw = ($urandom_range(0, 4) == 0) ? (CB-1)'($urandom) :
                                          (CB-1)'($urandom_range(0, 32'h00080000));
    rb.bh = ($urandom_range(0, 4) == 0) ? (CB-1)'($urandom) :
                                          (CB-1)'($urandom_range(0, 32'h00080000));
    // steer some rays straight at the box center
    if ($urandom_range(0, 1)) begin
      rb.dx = (rb.bl + $signed({1'b0, rb.bw >> 1})) - rb.ox;
      rb.dy = (rb.bt + $signed({1'b0, rb.bh >> 1})) - rb.oy;
    end
    // some small directions to exercise the parallel test
    if ($urandom_range(0, 7) == 0) rb.dx = $signed($urandom_range(0, 8)) - 4;
    if ($urandom_range(0, 7) == 0) rb.dy = $signed($urandom_range(0, 8)) - 4;
    return rb;
  endfunction

  // drive one beat and hold until taken; start stays high until a pause
  task automatic send_ray(ray_box_t rb);
    origin_x <= rb.ox; origin_y <= rb.oy; dir_x <= rb.dx; dir_y <= rb.dy;
    box_left <= rb.bl; box_top <= rb.bt; box_width <= rb.bw; box_height <= rb.bh;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    hit_queue.push_back(nearest_hit(rb));
    rays_sent++;
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // let the pipeline drain before touching the register
  task automatic drain();
    start <= 1'b0;
    while (hit_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_eps(logic [EPS_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    eps_model = v;
  endtask

  // check each result beat against the oldest prediction
  always @(posedge clk) begin
    slab_hit_t want;
    if (!rst && done) begin
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected result hit=%0b distance=%0h", $time, hit, distance);
        errors++;
      end else begin
        want = hit_queue.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
          errors++;
        end
        if (distance !== want.tval) begin
          $display("%0t: distance expected %0h actual %0h", $time, want.tval, distance);
          errors++;
        end
        if (want.hit) hits_seen++;
        else misses_seen++;
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, hit_queue.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    slab_hit_t pred;
    logic [EPS_BITS-1:0] eps_steps[4];
    errors = 0;
    rays_sent = 0;
    hits_seen = 0;
    misses_seen = 0;
    idle_cycles = 0;
    eps_model = EPS_RESET;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    origin_x = '0; origin_y = '0; dir_x = '0; dir_y = '0;
    box_left = '0; box_top = '0; box_width = '0; box_height = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table; known answers where obvious
    row.known = 1'b1;
    // both axes parallel, origin inside: infinite exit, so miss
    row.rb = mk(0, 0, 0, 0, -65536, -65536, 131072, 131072);
    row.ans = '{1'b0, '0}; rows.push_back(row);
    // parallel on x and outside slab: miss
    row.rb = mk(32'sh00050000, 0, 0, 65536, 0, 0, 65536, 65536);
    row.ans = '{1'b0, '0}; rows.push_back(row);
    // straight hit along x at t=1.0
    row.rb = mk(0, 32'sh00008000, 65536, 0, 65536, 0, 65536, 65536);
    row.ans = '{1'b1, 31'h10000}; rows.push_back(row);
    // origin inside, moving +x: exit time returned
    row.rb = mk(32'sh00008000, 32'sh00008000, 65536, 0, 0, 0, 65536, 65536);
    row.ans = '{1'b1, 31'h8000}; rows.push_back(row);
    // box behind the ray: miss
    row.rb = mk(32'sh00030000, 0, 65536, 0, 0, 0, 65536, 65536);
    row.ans = '{1'b0, '0}; rows.push_back(row);
    // origin touching the near edge: t=0
    row.rb = mk(0, 0, 65536, 65536, 0, 0, 65536, 65536);
    row.ans = '{1'b1, '0}; rows.push_back(row);
    row.known = 1'b0;
    // extremes of every field, saturating quotients, tiny directions
    row.rb = mk(-HALF, -HALF, 1, 1, HALF - 1, HALF - 1, HALF - 1, HALF - 1);
    rows.push_back(row);
    row.rb = mk(HALF - 1, HALF - 1, -HALF, -HALF, -HALF, -HALF, HALF - 1, HALF - 1);
    rows.push_back(row);
    row.rb = mk(-HALF, 0, HALF - 1, -1, -HALF, -HALF, HALF - 1, HALF - 1);
    rows.push_back(row);
    row.rb = mk(0, 0, -1, 1, -HALF, -HALF, 0, 0);
    rows.push_back(row);
    row.rb = mk(-1, -1, 2, 3, 0, 0, 1, 1);
    rows.push_back(row);
    row.rb = mk(32'sh7fff0000, -32'sh7fff0000, -2, 2, -10, -10, 20, 20);
    rows.push_back(row);
    row.rb = mk(0, 0, 32'sh00010000, -32'sh00010000, 32'sh00020000, -32'sh00030000,
                32'sh00010000, 32'sh00010000);
    rows.push_back(row);
    row.rb = mk(-32'sh00050000, 32'sh00050000, 32'sh00000003, -32'sh00010000,
                0, 0, 32'sh00010000, 32'sh00010000);
    rows.push_back(row);

    foreach (rows[i]) begin
      send_ray(rows[i].rb);
      pred = nearest_hit(rows[i].rb);
      if (rows[i].known && pred != rows[i].ans) begin
        $display("%0t: table row %0d expected %0b/%0h predicted %0b/%0h", $time, i,
                 rows[i].ans.hit, rows[i].ans.tval, pred.hit, pred.tval);
        errors++;
      end
      sender_gap();
    end

    // random phases, each under its own epsilon, extremes included
    eps_steps[0] = 16'd1;
    eps_steps[1] = 16'hFFFF;
    eps_steps[2] = EPS_BITS'($urandom_range(2, 16'hFFFE));
    eps_steps[3] = 16'd4;
    for (int p = 0; p < 4; p++) begin
      drain();
      write_eps(eps_steps[p]);
      // directed parallel checks around the new threshold
      send_ray(mk(0, 0, eps_steps[p], -eps_steps[p], -100, -100, 200, 200));
      send_ray(mk(0, 0, eps_steps[p] - 1, 1 - eps_steps[p], -100, -100, 200, 200));
      for (int n = 0; n < RANDOM_RAYS / 4; n++) begin
        send_ray(rand_ray());
        sender_gap();
        // once per phase, hold off until everything is back
        if (n == 100) begin
          start <= 1'b0;
          while (hit_queue.size() != 0) @(negedge clk);
        end
      end
    end

    start <= 1'b0;
    while (hit_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    $display("Sent %0d rays over 4 epsilon settings (1, 65535, random, 4)", rays_sent);
    $display("Saw %0d hits and %0d misses", hits_seen, misses_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
